// ===== hdl/pplf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paced packet link framer - shared definitions
// Mode and status codes, frame constants and the structs passed between the
// framer top level and its transmit queue and receive frame units.
// ----------------------------------------------------------------------------
package pplf_pkg;

  // Receive frame buffer geometry
  localparam int FRAME_SIZE = 32;
  localparam int FRAME_AW   = 5;
  localparam int FILL_W     = 6;

  // Link framing bytes
  localparam logic [7:0] PACKET_START = 8'hFF;
  localparam logic [7:0] END_BYTE     = 8'h00;

  // Item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Transmit status codes
  localparam logic [1:0] TXS_ACCEPTED = 2'd0;
  localparam logic [1:0] TXS_ENDED    = 2'd1;
  localparam logic [1:0] TXS_TOO_LONG = 2'd2;
  localparam logic [1:0] TXS_DISABLED = 2'd3;

  // Configuration registers
  localparam int         CFG_IDX_W      = 1;
  localparam int         CFG_DATA_W     = 16;
  localparam logic       REG_SEND_DELAY = 1'b0;
  localparam logic       REG_TX_ENABLE  = 1'b1;
  localparam logic [15:0] SEND_DELAY_RESET = 16'd7;
  localparam logic [15:0] PACE_RESET       = 16'd7;

  // Push request into the transmit queue: one byte, or a pair
  typedef struct packed {
    logic       vld;
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
  } txq_push_t;

  // Receive completion flags of one tick
  typedef struct packed {
    logic done;
    logic bad_header;
    logic overflow;
  } rx_status_t;

  // One result beat
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       flag_tx_busy;
    logic       flag_rx_done;
    logic       flag_bad_header;
    logic       flag_overflow;
    logic [7:0] last_type;
    logic [1:0] tx_status;
    logic [7:0] read_byte;
  } result_t;

endpackage

// ===== hdl/pplf_txq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transmit byte queue
// Circular queue in a single-write-port memory. A pair push writes the first
// byte at once and parks the second in a pending register that is written in
// the next cycle. The head byte is read into a register on each item beat.
// ----------------------------------------------------------------------------
module pplf_txq #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pplf_pkg::txq_push_t        push_i,
  input  logic                       pop_i,
  input  logic                       rd_en_i,
  output logic [$clog2(DEPTH+1)-1:0] fill_o,
  output logic                       pend_o,
  output logic [7:0]                 head_byte_o
);
  import pplf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [7:0]    mem_r [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW:0]   tail_sum;
  logic [AW-1:0] tail, tail_inc;
  logic          push_first, push_second;
  logic          pend_valid_r;
  logic [AW-1:0] pend_addr_r;
  logic [7:0]    pend_data_r;
  logic [7:0]    head_byte_r;

  // Tail position and pointer updates; full queue drops new bytes
  always_comb begin
    tail_sum = (FW+1)'(head_r) + (FW+1)'(fill_r);
    if (tail_sum >= (FW+1)'(DEPTH)) begin
      tail = AW'(tail_sum - (FW+1)'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
    tail_inc    = (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
    push_first  = push_i.vld && (fill_r < FW'(DEPTH));
    push_second = push_i.vld && push_i.two && (fill_r < FW'(DEPTH - 1));
    if (pop_i) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end else begin
      head_nxt = head_r;
    end
    fill_nxt = fill_r + FW'(push_first) + FW'(push_second) - FW'(pop_i);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      fill_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      pend_valid_r <= push_second;
    end
  end

  // Second byte of a pair waits in the pending register for the write port
  always_ff @(posedge clk) begin
    if (push_second) begin
      pend_addr_r <= tail_inc;
      pend_data_r <= push_i.second;
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (pend_valid_r) begin
      mem_r[pend_addr_r] <= pend_data_r;
    end else if (push_first) begin
      mem_r[tail] <= push_i.first;
    end
  end

  // Registered head read, with bypass of a pending write
  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      if (pend_valid_r && (pend_addr_r == head_r)) begin
        head_byte_r <= pend_data_r;
      end else begin
        head_byte_r <= mem_r[head_r];
      end
    end
  end

  assign fill_o      = fill_r;
  assign pend_o      = pend_valid_r;
  assign head_byte_o = head_byte_r;

  // Pending write drains in the next cycle and never meets a new push
  a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |=> !pend_valid_r)
    else $error("pending queue write held longer than one cycle");

  a_no_push_on_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !push_i.vld)
    else $error("push while pending write occupies the port");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (fill_r != '0))
    else $error("pop from empty transmit queue");

endmodule

// ===== hdl/pplf_rx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive frame collector
// Stores received bytes in a 32-entry frame buffer, detects frame completion
// on a zero byte or a full buffer, flags bad header and overflow, latches the
// type byte and clears the buffer on the following tick.
// ----------------------------------------------------------------------------
module pplf_rx (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  logic                          rx_valid_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [pplf_pkg::FRAME_AW-1:0] rd_idx_i,
  output pplf_pkg::rx_status_t          status_o,
  output logic [7:0]                    type_o,
  output logic [7:0]                    rd_byte_o
);
  import pplf_pkg::*;

  logic [7:0]          frame_r [FRAME_SIZE];
  logic [FILL_W-1:0]   fill_r, fill_nxt, fill_eff, fill_inc;
  logic                clear_r, clear_nxt;
  logic [7:0]          latch_r, latch_nxt, latch_eff;
  logic [FRAME_AW-1:0] wr_idx;
  logic                full, byte_zero;
  logic [7:0]          head0, head1, wr_data;
  rx_status_t          status;

  // Frame completion and next state for a tick beat
  always_comb begin
    fill_eff  = clear_r ? '0 : fill_r;
    latch_eff = clear_r ? '0 : latch_r;
    wr_idx    = fill_eff[FRAME_AW-1:0];
    fill_inc  = (fill_eff < FILL_W'(FRAME_SIZE)) ? fill_eff + 1'b1 : fill_eff;
    full      = (fill_inc == FILL_W'(FRAME_SIZE));
    byte_zero = (rx_byte_i == END_BYTE);
    head0     = (wr_idx == '0) ? rx_byte_i : frame_r[0];
    head1     = (wr_idx == FRAME_AW'(1)) ? rx_byte_i : frame_r[1];

    status.done       = en_i && rx_valid_i && (byte_zero || full);
    status.bad_header = status.done && (head0 != PACKET_START);
    status.overflow   = status.done && full && !byte_zero;
    wr_data           = status.overflow ? END_BYTE : rx_byte_i;

    fill_nxt  = fill_r;
    clear_nxt = clear_r;
    latch_nxt = latch_r;
    if (en_i) begin
      fill_nxt  = rx_valid_i ? fill_inc : fill_eff;
      clear_nxt = status.done;
      latch_nxt = status.done ? head1 : latch_eff;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      clear_r <= 1'b1;
      latch_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      clear_r <= clear_nxt;
      latch_r <= latch_nxt;
    end
  end

  // Frame buffer write
  always_ff @(posedge clk) begin
    if (en_i && rx_valid_i) begin
      frame_r[wr_idx] <= wr_data;
    end
  end

  assign status_o  = status;
  assign type_o    = latch_nxt;
  assign rd_byte_o = frame_r[rd_idx_i];

  // A full buffer always has its clear scheduled
  a_full_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == FILL_W'(FRAME_SIZE)) |-> clear_r)
    else $error("full frame buffer without pending clear");

  a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (en_i && clear_r) |=> (fill_r <= FILL_W'(1)))
    else $error("frame buffer not restarted after clear");

  a_overflow_last: assert property (@(posedge clk) disable iff (!rst_n)
    status.overflow |-> (wr_idx == FRAME_AW'(FRAME_SIZE - 1)))
    else $error("overflow reported away from last frame entry");

endmodule

// ===== hdl/paced_packet_link_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paced packet link framer - top level
// Queues framed packets for a byte link, paces them out on tick items,
// collects received frames and answers frame buffer reads.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls or a push waits for the
// write port; its result beat goes through a stage register and an output
// register, which absorb an output stall. A transmit-start or transmit-data
// item that directly follows a start that queued its type byte is held back:
// the queue memory has one write port, and the type byte of a start takes it
// in the cycle after the 0xFF. The transmit queue needs no clearing after
// reset. Configuration writes are always ready and take effect at once.
module paced_packet_link_framer #(
  parameter int TX_QUEUE_DEPTH = 64,
  parameter int DATA_MAX       = 30
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic                            in_link_ready,
  input  logic                            in_rx_valid,
  input  logic [7:0]                      in_rx_byte,
  input  logic [7:0]                      in_packet_type,
  input  logic [7:0]                      in_payload_byte,
  input  logic [pplf_pkg::FRAME_AW-1:0]   in_read_index,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_tx_valid,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_flag_tx_busy,
  output logic                            out_flag_rx_done,
  output logic                            out_flag_bad_header,
  output logic                            out_flag_overflow,
  output logic [7:0]                      out_last_type,
  output logic [1:0]                      out_tx_status,
  output logic [7:0]                      out_read_byte,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pplf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pplf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pplf_pkg::*;

  localparam int QFW = $clog2(TX_QUEUE_DEPTH + 1);
  localparam int CW  = $clog2(DATA_MAX + 1);

  logic [15:0]    send_delay_r;
  logic           tx_enable_r;
  logic [15:0]    pace_r, pace_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic           open_r, open_nxt;
  logic           s1_valid_r, out_valid_r;
  result_t        s1_r, out_r, out_nxt, res;
  logic           accept, s1_adv, is_push_mode, rx_en;
  logic           pop_req;
  txq_push_t      push_req, push;
  logic [QFW-1:0] q_fill;
  logic           q_pend;
  logic [7:0]     head_byte;
  rx_status_t     rx_status;
  logic [7:0]     rx_type, rx_rd;

  // Handshake: stall a push while the queue write port is taken
  assign is_push_mode = (in_mode == MODE_START) || (in_mode == MODE_DATA);
  assign s1_adv       = !out_valid_r || out_ready;
  assign in_ready     = (!s1_valid_r || s1_adv) && !(q_pend && is_push_mode);
  assign accept       = in_valid && in_ready;
  assign rx_en        = accept && (in_mode == MODE_TICK);
  assign cfg_ready    = 1'b1;

  // Per-item decode
  always_comb begin
    res      = '0;
    push_req = '0;
    pop_req  = 1'b0;
    pace_nxt = pace_r;
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    cnt_inc  = cnt_r + 1'b1;
    unique case (in_mode)
      MODE_TICK: begin
        res.flag_tx_busy    = (q_fill != '0) && in_link_ready;
        res.flag_rx_done    = rx_status.done;
        res.flag_bad_header = rx_status.bad_header;
        res.flag_overflow   = rx_status.overflow;
        if (res.flag_tx_busy) begin
          if (pace_r == '0) begin
            pop_req      = 1'b1;
            res.tx_valid = 1'b1;
            pace_nxt     = send_delay_r;
          end else begin
            pace_nxt = pace_r - 16'd1;
          end
        end
      end
      MODE_START: begin
        if (!tx_enable_r) begin
          res.tx_status = TXS_DISABLED;
        end else begin
          push_req.vld    = 1'b1;
          push_req.two    = 1'b1;
          push_req.first  = PACKET_START;
          push_req.second = in_packet_type;
          open_nxt        = 1'b1;
          cnt_nxt         = '0;
        end
      end
      MODE_DATA: begin
        if (!tx_enable_r) begin
          res.tx_status = TXS_DISABLED;
        end else if (!open_r) begin
          res.tx_status = TXS_ENDED;
        end else begin
          push_req.vld   = 1'b1;
          push_req.first = in_payload_byte;
          cnt_nxt        = cnt_inc;
          if (in_payload_byte == END_BYTE) begin
            open_nxt      = 1'b0;
            res.tx_status = TXS_ENDED;
          end else if (cnt_inc >= CW'(DATA_MAX)) begin
            open_nxt      = 1'b0;
            res.tx_status = TXS_TOO_LONG;
          end
        end
      end
      MODE_READ: begin
        res.read_byte = rx_rd;
      end
      default: begin
        res = '0;
      end
    endcase
    res.last_type = rx_type;
  end

  // Queue requests only on an accepted beat
  always_comb begin
    push     = push_req;
    push.vld = accept && push_req.vld;
  end

  pplf_txq #(
    .DEPTH(TX_QUEUE_DEPTH)
  ) u_txq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .pop_i       (accept && pop_req),
    .rd_en_i     (accept),
    .fill_o      (q_fill),
    .pend_o      (q_pend),
    .head_byte_o (head_byte)
  );

  pplf_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .en_i       (rx_en),
    .rx_valid_i (in_rx_valid),
    .rx_byte_i  (in_rx_byte),
    .rd_idx_i   (in_read_index),
    .status_o   (rx_status),
    .type_o     (rx_type),
    .rd_byte_o  (rx_rd)
  );

  // Control state, configuration and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_delay_r <= SEND_DELAY_RESET;
      tx_enable_r  <= 1'b0;
      pace_r       <= PACE_RESET;
      cnt_r        <= '0;
      open_r       <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SEND_DELAY: send_delay_r <= cfg_data;
          REG_TX_ENABLE:  tx_enable_r  <= cfg_data[0];
          default:        send_delay_r <= send_delay_r;
        endcase
      end
      if (accept) begin
        pace_r <= pace_nxt;
        cnt_r  <= cnt_nxt;
        open_r <= open_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Sent byte joins from the queue read register
  always_comb begin
    out_nxt         = s1_r;
    out_nxt.tx_byte = s1_r.tx_valid ? head_byte : 8'h00;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= res;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_valid        = out_r.tx_valid;
  assign out_tx_byte         = out_r.tx_byte;
  assign out_flag_tx_busy    = out_r.flag_tx_busy;
  assign out_flag_rx_done    = out_r.flag_rx_done;
  assign out_flag_bad_header = out_r.flag_bad_header;
  assign out_flag_overflow   = out_r.flag_overflow;
  assign out_last_type       = out_r.last_type;
  assign out_tx_status       = out_r.tx_status;
  assign out_read_byte       = out_r.read_byte;

endmodule

// ===== sim/paced_packet_link_framer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paced packet link framer - result checker
// Watches the item, result and register-write channels of the framer. Every
// accepted item is run through a behavioral copy of the framer, and the
// expected result beat is queued. Each result beat is compared field by
// field with the oldest queued one. The mismatch count and the number of
// beats still awaited are passed to the testbench top.
// ----------------------------------------------------------------------------
module paced_packet_link_framer_checker #(
  parameter int TX_QUEUE_DEPTH = 64,
  parameter int DATA_MAX       = 30
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic                            in_link_ready,
  input  logic                            in_rx_valid,
  input  logic [7:0]                      in_rx_byte,
  input  logic [7:0]                      in_packet_type,
  input  logic [7:0]                      in_payload_byte,
  input  logic [pplf_pkg::FRAME_AW-1:0]   in_read_index,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_tx_valid,
  input  logic [7:0]                      out_tx_byte,
  input  logic                            out_flag_tx_busy,
  input  logic                            out_flag_rx_done,
  input  logic                            out_flag_bad_header,
  input  logic                            out_flag_overflow,
  input  logic [7:0]                      out_last_type,
  input  logic [1:0]                      out_tx_status,
  input  logic [7:0]                      out_read_byte,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pplf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pplf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import pplf_pkg::*;

  localparam int QW = $clog2(TX_QUEUE_DEPTH);
  localparam int LW = $clog2(DATA_MAX + 1) + 1;

  // Register copies
  logic [15:0]        delay_reg;
  logic               tx_en;

  // Transmit side
  logic [7:0]         txq_mem [TX_QUEUE_DEPTH];
  logic [QW-1:0]      txq_head;
  logic [QW:0]        txq_fill;
  logic [15:0]        pace;
  logic [LW-1:0]      pkt_len;
  logic               pkt_open;

  // Receive side
  logic [7:0]         frame_mem [FRAME_SIZE];
  logic [FILL_W-1:0]  frame_fill;
  logic               frame_clear;
  logic [7:0]         latched_type;

  result_t            pending_results [$];

  // Full queue keeps what it has and drops the new byte
  function automatic void queue_byte(logic [7:0] b);
    if (txq_fill < TX_QUEUE_DEPTH) begin
      txq_mem[(txq_head + txq_fill) % TX_QUEUE_DEPTH] = b;
      txq_fill = txq_fill + 1'b1;
    end
  endfunction

  // Result beat of one item; advances the framer state
  function automatic result_t framer_result(logic [1:0] mode, logic link_rdy, logic rx_vld,
                                            logic [7:0] rx_b, logic [7:0] ptype,
                                            logic [7:0] pbyte, logic [FRAME_AW-1:0] ridx);
    result_t r;
    logic    full;
    r = '0;
    case (mode)
      MODE_TICK: begin
        // previous frame completed: start over
        if (frame_clear) begin
          frame_fill   = '0;
          frame_clear  = 1'b0;
          latched_type = 8'h00;
        end
        // pacing only runs while there is something to send and the link is ready
        if (txq_fill != 0 && link_rdy) begin
          r.flag_tx_busy = 1'b1;
          if (pace == 0) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = txq_mem[txq_head];
            txq_head   = (txq_head + 1) % TX_QUEUE_DEPTH;
            txq_fill   = txq_fill - 1'b1;
            pace       = delay_reg;
          end else begin
            pace = pace - 1'b1;
          end
        end
        if (rx_vld) begin
          frame_mem[frame_fill[FRAME_AW-1:0]] = rx_b;
          if (frame_fill < FRAME_SIZE) frame_fill = frame_fill + 1'b1;
          full = (frame_fill == FRAME_SIZE);
          if (rx_b == END_BYTE || full) begin
            r.flag_rx_done    = 1'b1;
            r.flag_bad_header = (frame_mem[0] != PACKET_START);
            // full buffer without terminator: last entry forced to zero
            if (full && rx_b != END_BYTE) begin
              r.flag_overflow           = 1'b1;
              frame_mem[FRAME_SIZE - 1] = END_BYTE;
            end
            latched_type = frame_mem[1];
            frame_clear  = 1'b1;
          end
        end
      end
      MODE_START: begin
        if (!tx_en) begin
          r.tx_status = TXS_DISABLED;
        end else begin
          queue_byte(PACKET_START);
          queue_byte(ptype);
          pkt_open = 1'b1;
          pkt_len  = '0;
        end
      end
      MODE_DATA: begin
        if (!tx_en) begin
          r.tx_status = TXS_DISABLED;
        end else if (!pkt_open) begin
          r.tx_status = TXS_ENDED;
        end else begin
          queue_byte(pbyte);
          pkt_len = pkt_len + 1'b1;
          if (pbyte == END_BYTE) begin
            pkt_open    = 1'b0;
            r.tx_status = TXS_ENDED;
          end else if (pkt_len >= DATA_MAX) begin
            pkt_open    = 1'b0;
            r.tx_status = TXS_TOO_LONG;
          end
        end
      end
      MODE_READ: begin
        r.read_byte = frame_mem[ridx];
      end
    endcase
    r.last_type = latched_type;
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Predict on item beats, compare on result beats
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      delay_reg    = SEND_DELAY_RESET;
      tx_en        = 1'b0;
      txq_head     = '0;
      txq_fill     = '0;
      pace         = PACE_RESET;
      pkt_len      = '0;
      pkt_open     = 1'b0;
      frame_fill   = '0;
      frame_clear  = 1'b1;
      latched_type = 8'h00;
      pending_results.delete();
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SEND_DELAY) delay_reg = cfg_data;
        else if (cfg_index == REG_TX_ENABLE) tx_en = cfg_data[0];
      end
      if (in_valid && in_ready)
        pending_results.push_back(framer_result(in_mode, in_link_ready, in_rx_valid,
                                                in_rx_byte, in_packet_type,
                                                in_payload_byte, in_read_index));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no item waiting for it");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("tx_valid", want.tx_valid, out_tx_valid);
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("flag_tx_busy", want.flag_tx_busy, out_flag_tx_busy);
          check_field("flag_rx_done", want.flag_rx_done, out_flag_rx_done);
          check_field("flag_bad_header", want.flag_bad_header, out_flag_bad_header);
          check_field("flag_overflow", want.flag_overflow, out_flag_overflow);
          check_field("last_type", want.last_type, out_last_type);
          check_field("tx_status", want.tx_status, out_tx_status);
          check_field("read_byte", want.read_byte, out_read_byte);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== sim/paced_packet_link_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paced packet link framer - testbench top
// Drives a short directed run, then phases of random transmit packets,
// received link frames, reads and noise under several register settings,
// with random gaps on both channels and one long output stall. Checking is
// done by the checker module beside the framer; this top gives the verdict.
// ----------------------------------------------------------------------------
module paced_packet_link_framer_tb;
  import pplf_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 115;
  localparam int HOLD_AT_BEAT = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [1:0]          mode;
    logic                link_ready;
    logic                rx_valid;
    logic [7:0]          rx_byte;
    logic [7:0]          packet_type;
    logic [7:0]          payload_byte;
    logic [FRAME_AW-1:0] read_index;
  } link_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_mode;
  logic                  in_link_ready;
  logic                  in_rx_valid;
  logic [7:0]            in_rx_byte;
  logic [7:0]            in_packet_type;
  logic [7:0]            in_payload_byte;
  logic [FRAME_AW-1:0]   in_read_index;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_tx_valid;
  logic [7:0]            out_tx_byte;
  logic                  out_flag_tx_busy;
  logic                  out_flag_rx_done;
  logic                  out_flag_bad_header;
  logic                  out_flag_overflow;
  logic [7:0]            out_last_type;
  logic [1:0]            out_tx_status;
  logic [7:0]            out_read_byte;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  // Which frame buffer entries have been written, tracked in issue order
  int                    rx_pos     = 0;
  bit                    rx_restart = 1'b1;
  int                    rx_high    = 0;

  logic [7:0]            rx_script [$];  // link bytes of the frame being received
  link_item_t            tx_script [$];  // items of the packet being queued
  int                    sent       = 0;
  int                    send_style = 0;

  paced_packet_link_framer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_link_ready       (in_link_ready),
    .in_rx_valid         (in_rx_valid),
    .in_rx_byte          (in_rx_byte),
    .in_packet_type      (in_packet_type),
    .in_payload_byte     (in_payload_byte),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_flag_tx_busy    (out_flag_tx_busy),
    .out_flag_rx_done    (out_flag_rx_done),
    .out_flag_bad_header (out_flag_bad_header),
    .out_flag_overflow   (out_flag_overflow),
    .out_last_type       (out_last_type),
    .out_tx_status       (out_tx_status),
    .out_read_byte       (out_read_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  paced_packet_link_framer_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_link_ready       (in_link_ready),
    .in_rx_valid         (in_rx_valid),
    .in_rx_byte          (in_rx_byte),
    .in_packet_type      (in_packet_type),
    .in_payload_byte     (in_payload_byte),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_flag_tx_busy    (out_flag_tx_busy),
    .out_flag_rx_done    (out_flag_rx_done),
    .out_flag_bad_header (out_flag_bad_header),
    .out_flag_overflow   (out_flag_overflow),
    .out_last_type       (out_last_type),
    .out_tx_status       (out_tx_status),
    .out_read_byte       (out_read_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle style: 0 none, 1 short gaps, 2 long gaps
  function automatic int draw_gap(int style);
    if (style == 0) return 0;
    if (style == 1) return $urandom_range(0, 3);
    return $urandom_range(0, 17);
  endfunction

  // All fields random; callers set what their mode needs
  function automatic link_item_t random_item();
    link_item_t it;
    it.mode         = 2'($urandom_range(0, 3));
    it.link_ready   = 1'($urandom_range(0, 1));
    it.rx_valid     = 1'($urandom_range(0, 1));
    it.rx_byte      = 8'($urandom_range(0, 255));
    it.packet_type  = 8'($urandom_range(0, 255));
    it.payload_byte = 8'($urandom_range(0, 255));
    it.read_index   = FRAME_AW'($urandom_range(0, FRAME_SIZE - 1));
    return it;
  endfunction

  function automatic link_item_t tick_item(logic ready, logic rv, logic [7:0] b);
    link_item_t it;
    it            = random_item();
    it.mode       = MODE_TICK;
    it.link_ready = ready;
    it.rx_valid   = rv;
    it.rx_byte    = b;
    return it;
  endfunction

  function automatic link_item_t start_item(logic [7:0] t);
    link_item_t it;
    it             = random_item();
    it.mode        = MODE_START;
    it.packet_type = t;
    return it;
  endfunction

  function automatic link_item_t data_item(logic [7:0] b);
    link_item_t it;
    it              = random_item();
    it.mode         = MODE_DATA;
    it.payload_byte = b;
    return it;
  endfunction

  function automatic link_item_t read_item(logic [FRAME_AW-1:0] idx);
    link_item_t it;
    it            = random_item();
    it.mode       = MODE_READ;
    it.read_index = idx;
    return it;
  endfunction

  // Mostly ticks; received bytes follow frame scripts, transmit items packet scripts
  function automatic link_item_t next_random_item();
    link_item_t it;
    int         pick;
    int         len;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it = tick_item($urandom_range(0, 7) != 0, 1'b0, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) begin
        if (rx_script.size() == 0) begin
          if ($urandom_range(0, 4) != 0) begin
            // well-formed frame, now and then long enough to overflow
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 33) : $urandom_range(0, 8);
            rx_script.push_back(PACKET_START);
            rx_script.push_back(8'($urandom_range(0, 255)));
            repeat (len) rx_script.push_back(8'($urandom_range(1, 255)));
            rx_script.push_back(END_BYTE);
          end else begin
            // line noise, zeros among it
            repeat ($urandom_range(1, 4))
              rx_script.push_back(($urandom_range(0, 2) == 0) ? END_BYTE
                                                              : 8'($urandom_range(0, 255)));
          end
        end
        it.rx_valid = 1'b1;
        it.rx_byte  = rx_script.pop_front();
      end
    end else if (pick < 85) begin
      if (tx_script.size() == 0) begin
        // some packets run past the data limit, some never get their end byte
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(27, 32) : $urandom_range(0, 6);
        tx_script.push_back(start_item(8'($urandom_range(0, 255))));
        repeat (len) tx_script.push_back(data_item(8'($urandom_range(1, 255))));
        if ($urandom_range(0, 9) != 0) tx_script.push_back(data_item(END_BYTE));
      end
      it = tx_script.pop_front();
    end else if (pick < 95) begin
      it = read_item(FRAME_AW'($urandom_range(0, FRAME_SIZE - 1)));
    end else begin
      it = random_item();
    end
    return it;
  endfunction

  // One item beat; called at a clock edge, returns at the edge it is taken
  task automatic send_item(input link_item_t it);
    int gap;
    if (sent % 40 == 0) send_style = $urandom_range(0, 2);
    sent++;
    gap = draw_gap(send_style);
    // reads stay on written entries
    if (it.mode == MODE_READ) begin
      if (rx_high == 0) it.mode = MODE_TICK;
      else if (it.read_index >= rx_high)
        it.read_index = FRAME_AW'($urandom_range(0, rx_high - 1));
    end
    if (it.mode == MODE_TICK) begin
      if (rx_restart) begin
        rx_pos     = 0;
        rx_restart = 1'b0;
      end
      if (it.rx_valid) begin
        // a frame ended by its first byte latches entry 1, so that must exist
        if (rx_pos == 0 && it.rx_byte == END_BYTE && rx_high < 2) it.rx_byte = 8'h01;
        if (rx_pos >= rx_high) rx_high = rx_pos + 1;
        rx_pos++;
        if (it.rx_byte == END_BYTE || rx_pos == FRAME_SIZE) rx_restart = 1'b1;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode         <= it.mode;
    in_link_ready   <= it.link_ready;
    in_rx_valid     <= it.rx_valid;
    in_rx_byte      <= it.rx_byte;
    in_packet_type  <= it.packet_type;
    in_payload_byte <= it.payload_byte;
    in_read_index   <= it.read_index;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Let every result come back, then write both registers
  task automatic settle_and_configure(input logic [15:0] delay, input logic enable);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_index <= REG_SEND_DELAY;
    cfg_data  <= delay;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_index <= REG_TX_ENABLE;
    cfg_data  <= {{(CFG_DATA_W - 1){1'b0}}, enable};
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off to back the framer up
  initial begin
    int stall;
    int beats;
    int style;
    beats     = 0;
    style     = 0;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (beats % 40 == 0) style = $urandom_range(0, 2);
      if (beats == HOLD_AT_BEAT) stall = HOLD_CYCLES;
      else stall = draw_gap(style);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      beats++;
    end
  end

  // Watchdog: too long without a beat on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("paced_packet_link_framer: mismatch");
    $finish;
  end

  initial begin
    logic [15:0] delay;
    logic        enable;
    in_valid        = 1'b0;
    in_mode         = MODE_TICK;
    in_link_ready   = 1'b0;
    in_rx_valid     = 1'b0;
    in_rx_byte      = 8'h00;
    in_packet_type  = 8'h00;
    in_payload_byte = 8'h00;
    in_read_index   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_SEND_DELAY;
    cfg_data        = '0;
    rst_n           = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Transmit disabled out of reset
    send_item(tick_item(1'b0, 1'b0, 8'h00));
    send_item(start_item(PACKET_START));
    send_item(data_item(END_BYTE));

    // Enabled, no pacing delay
    settle_and_configure(16'd0, 1'b1);
    send_item(data_item(8'h55));          // no packet open
    send_item(start_item(8'h00));
    send_item(data_item(8'hFF));
    send_item(data_item(END_BYTE));       // packet ended
    send_item(start_item(PACKET_START));
    send_item(start_item(8'h7E));         // restart over an open packet
    send_item(data_item(8'h01));
    send_item(tick_item(1'b0, 1'b0, 8'hFF));  // link not ready with bytes queued
    // good frame
    send_item(tick_item(1'b1, 1'b1, PACKET_START));
    send_item(tick_item(1'b1, 1'b1, 8'hA5));
    send_item(tick_item(1'b1, 1'b1, 8'hFF));
    send_item(tick_item(1'b1, 1'b1, END_BYTE));
    // bad header
    send_item(tick_item(1'b1, 1'b1, 8'h12));
    send_item(tick_item(1'b1, 1'b1, 8'h34));
    send_item(tick_item(1'b1, 1'b1, END_BYTE));
    // frame ended by its first byte: stale type
    send_item(tick_item(1'b1, 1'b1, END_BYTE));
    send_item(read_item(5'd0));
    send_item(read_item(5'd1));
    send_item(read_item(5'd3));
    send_item(tick_item(1'b1, 1'b1, 8'h80));

    // Random phases; the largest delay last, since it stalls sending for good
    for (int ph = 0; ph < PHASES; ph++) begin
      enable = 1'b1;
      case (ph)
        0:       delay = 16'd7;
        1:       delay = 16'd12;
        2:       delay = 16'd0;
        3:       delay = 16'($urandom_range(1, 40));
        4: begin
          delay  = 16'd3;
          enable = 1'b0;
        end
        5:       delay = 16'd1;
        6:       delay = 16'($urandom_range(2, 10));
        default: delay = 16'hFFFF;
      endcase
      settle_and_configure(delay, enable);
      repeat (PHASE_ITEMS) send_item(next_random_item());
    end

    // Drain, then keep clocking for any stray beat
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("paced_packet_link_framer: match");
    else
      $display("paced_packet_link_framer: mismatch");
    $finish;
  end

endmodule
